@@ sv/ldm_pkg.sv @@
// ldm_pkg: widths, register indexes, opcodes and shared types
// for the load cell deadzone mapper; no dependencies
`default_nettype none

package ldm_pkg;

  // field and datapath widths
  localparam int RAW_W     = 24;  // converter sample, zero and full scale
  localparam int FRAC_W    = 16;  // Q0.16 deadzone fraction
  localparam int LEVEL_W   = 16;  // mapped output level
  localparam int SUM_W     = 27;  // calibration accumulator
  localparam int CNT_W     = 3;   // calibration sample counter
  localparam int RNG_W     = RAW_W + 1;   // full scale minus zero
  localparam int DIFF_W    = RAW_W + 2;   // thresholds and sample offsets
  localparam int PROD_W    = RAW_W + FRAC_W;
  localparam int QUO_W     = SUM_W - 1;   // magnitude of the calibration sum
  localparam int ITER_W    = $clog2(QUO_W + 1);
  localparam int CFG_IDX_W = 2;

  // defaults for the top level parameters
  localparam int OUT_MAX_DEF     = 1023;
  localparam int CAL_SAMPLES_DEF = 5;

  // register reset values
  localparam logic signed [RAW_W-1:0] FULL_SCALE_RESET = 24'sh7FFFFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_DEAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_DEAD = 2'd2;

  // opcodes
  localparam logic OP_MAP = 1'b0;
  localparam logic OP_CAL = 1'b1;

  // divider pass lengths: map quotient is below 2^16 after the saturation check
  localparam logic [ITER_W-1:0] MAP_DIV_STEPS = ITER_W'(LEVEL_W);
  localparam logic [ITER_W-1:0] CAL_DIV_STEPS = ITER_W'(QUO_W);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_THRESH,
    S_SNAP,
    S_SCALE,
    S_CHECK,
    S_DIVIDE,
    S_CALDIV,
    S_WRITE
  } state_t;

  // divider launch request
  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] steps;
  } div_req_t;

endpackage

`default_nettype wire

@@ sv/ldm_mul_serial.sv @@
// ldm_mul_serial: unsigned shift-add multiplier, one multiplier bit per cycle
// depends on ldm_pkg for default widths
`default_nettype none

module ldm_mul_serial import ldm_pkg::*; #(
  parameter int AW = RAW_W,
  parameter int BW = FRAC_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             busy,
  output logic [AW+BW-1:0] prod
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] a_hold;
  logic [CW-1:0] steps;
  logic [AW:0]   hi_sum;

  // add the multiplicand into the upper half when the low bit is set
  assign hi_sum = {1'b0, prod[AW+BW-1:BW]} + (prod[0] ? {1'b0, a_hold} : '0);

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= CW'(BW);
    end else if (busy) begin
      steps <= steps - CW'(1);
      if (steps == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // product shifts right one bit per step, multiplier bits drop off the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      a_hold <= a;
      prod   <= {{AW{1'b0}}, b};
    end else if (busy) begin
      prod <= {hi_sum, prod[BW-1:1]};
    end
  end

endmodule

`default_nettype wire

@@ sv/ldm_div_serial.sv @@
// ldm_div_serial: unsigned restoring divider, one quotient bit per cycle
// depends on ldm_pkg for default widths and the request struct
`default_nettype none

module ldm_div_serial import ldm_pkg::*; #(
  parameter int DVD_W = QUO_W,
  parameter int DVS_W = RAW_W
) (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  input  logic [DVS_W-1:0] rem_init,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  logic [DVS_W-1:0]  rem;
  logic [DVD_W-1:0]  dvd_sh;
  logic [DVS_W-1:0]  dvs_hold;
  logic [ITER_W-1:0] steps;
  logic [DVS_W:0]    r_sh;
  logic [DVS_W:0]    r_sub;
  logic              fits;

  // trial subtract of the divisor from the shifted partial remainder
  assign r_sh  = {rem, dvd_sh[DVD_W-1]};
  assign fits  = r_sh >= {1'b0, dvs_hold};
  assign r_sub = r_sh - {1'b0, dvs_hold};

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      steps <= req.steps;
    end else if (busy) begin
      steps <= steps - ITER_W'(1);
      if (steps == ITER_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // remainder, dividend and quotient shift registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= rem_init;
      dvd_sh   <= dividend;
      dvs_hold <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? r_sub[DVS_W-1:0] : r_sh[DVS_W-1:0];
      dvd_sh   <= {dvd_sh[DVD_W-2:0], 1'b0};
      quotient <= {quotient[DVD_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ sv/load_cell_deadzone_mapper.sv @@
// Load cell deadzone mapper. One sample beat in, one result beat out. A map
// beat computes both deadzone thresholds on two 16-step serial multipliers,
// snaps the sample, forms (sample - zero) * OUT_MAX on a further 16-step
// multiplier pass and divides by the range on a 16-step restoring divider;
// quotients that would reach 2^16 saturate and negative quotients give zero,
// both without dividing. A map beat runs those three serial passes between
// acceptance and its result; with zero range it skips them. A calibration
// beat that completes the set runs a 26-step divide for the new zero; other
// calibration beats skip it. One beat is in work at a time; a finished result
// waits in the output register while the next sample beat is taken.
// Depends on ldm_pkg, ldm_mul_serial and ldm_div_serial.
`default_nettype none

module load_cell_deadzone_mapper import ldm_pkg::*; #(
  parameter int OUT_MAX     = OUT_MAX_DEF,
  parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [RAW_W-1:0]           cfg_data,
  // sample channel
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  logic                       opcode,
  input  logic                       sample_ready,
  input  logic signed [RAW_W-1:0]    raw_sample,
  // result channel
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [LEVEL_W-1:0]         mapped_level,
  output logic                       calibration_done,
  output logic signed [RAW_W-1:0]    zero_value
);

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(OUT_MAX);

  // registers
  logic signed [RAW_W-1:0] full_scale_raw;
  logic [FRAC_W-1:0]       lower_dead_fraction;
  logic [FRAC_W-1:0]       upper_dead_fraction;

  // model state
  logic signed [RAW_W-1:0] held_sample;
  logic signed [RAW_W-1:0] zero_reading;
  logic signed [SUM_W-1:0] cal_sum;
  logic [CNT_W-1:0]        cal_count;

  state_t state, state_next;

  // per-beat working registers
  logic               quo_neg;
  logic [LEVEL_W-1:0] res_level;
  logic               res_done;

  // handshake
  logic accept;
  logic slot_free;

  // calibration path
  logic signed [RAW_W-1:0] x_in;
  logic signed [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0]        cnt_inc;
  logic                    cal_fire;
  logic                    sum_neg;
  logic [QUO_W-1:0]        abs_sum;

  // range and thresholds
  logic signed [RNG_W-1:0]  range_w;
  logic                     r_neg;
  logic                     range_zero;
  logic [RAW_W-1:0]         abs_r;
  logic [RAW_W-1:0]         ql;
  logic [RAW_W-1:0]         qu;
  logic signed [DIFF_W-1:0] off_lo;
  logic signed [DIFF_W-1:0] off_up;
  logic signed [DIFF_W-1:0] zero_w;
  logic signed [DIFF_W-1:0] full_w;
  logic signed [DIFF_W-1:0] x_w;
  logic signed [DIFF_W-1:0] lo_th;
  logic signed [DIFF_W-1:0] hi_th;
  logic signed [DIFF_W-1:0] xs_w;
  logic signed [DIFF_W-1:0] d_w;
  logic                     d_neg;
  logic [RAW_W-1:0]         abs_d;

  // scaling and division
  logic [RAW_W-1:0]        n_hi;
  logic                    n_sat;
  logic [LEVEL_W-1:0]      quo_level;
  logic [LEVEL_W-1:0]      q_level;
  logic [RAW_W-1:0]        cal_q;
  logic signed [RAW_W-1:0] new_zero;

  // serial unit hookup
  logic               mlo_start;
  logic               mup_start;
  logic [RAW_W-1:0]   mlo_a;
  logic [FRAC_W-1:0]  mlo_b;
  logic               mlo_busy;
  logic               mup_busy;
  logic [PROD_W-1:0]  mlo_prod;
  logic [PROD_W-1:0]  mup_prod;
  div_req_t           div_req;
  logic [RAW_W-1:0]   div_rem;
  logic [QUO_W-1:0]   div_dvd;
  logic [RAW_W-1:0]   div_dvs;
  logic               div_busy;
  logic [QUO_W-1:0]   div_quo;

  assign accept       = sample_valid && !sample_stall;
  assign sample_stall = (state != S_IDLE);
  assign slot_free    = !result_valid || !result_stall;

  // calibration accumulate
  assign x_in     = sample_ready ? raw_sample : held_sample;
  assign sum_next = cal_sum + SUM_W'(x_in);
  assign cnt_inc  = cal_count + CNT_W'(1);
  assign cal_fire = cnt_inc >= CNT_W'(CAL_SAMPLES);
  assign sum_neg  = sum_next[SUM_W-1];
  assign abs_sum  = sum_neg ? QUO_W'(-sum_next) : QUO_W'(sum_next);

  // range magnitude and sign
  assign range_w    = RNG_W'(full_scale_raw) - RNG_W'(zero_reading);
  assign r_neg      = range_w[RNG_W-1];
  assign range_zero = (range_w == '0);
  assign abs_r      = r_neg ? RAW_W'(-range_w) : RAW_W'(range_w);

  // deadzone thresholds, truncated toward zero through the range sign
  assign ql     = mlo_prod[PROD_W-1:FRAC_W];
  assign qu     = mup_prod[PROD_W-1:FRAC_W];
  assign off_lo = r_neg ? -$signed({2'b00, ql}) : $signed({2'b00, ql});
  assign off_up = r_neg ? -$signed({2'b00, qu}) : $signed({2'b00, qu});
  assign zero_w = DIFF_W'(zero_reading);
  assign full_w = DIFF_W'(full_scale_raw);
  assign x_w    = DIFF_W'(held_sample);
  assign lo_th  = zero_w + off_lo;
  assign hi_th  = full_w - off_up;

  // snap into the deadzones
  always_comb begin
    priority if (x_w < lo_th) begin
      xs_w = zero_w;
    end else if (x_w > hi_th) begin
      xs_w = full_w;
    end else begin
      xs_w = x_w;
    end
  end

  assign d_w   = xs_w - zero_w;
  assign d_neg = d_w[DIFF_W-1];
  assign abs_d = d_neg ? RAW_W'(-d_w) : RAW_W'(d_w);

  // saturation check: quotient reaches 2^16 when the upper product half >= range
  assign n_hi  = mlo_prod[PROD_W-1:FRAC_W];
  assign n_sat = n_hi >= abs_r;

  // clamp the map quotient
  assign quo_level = div_quo[LEVEL_W-1:0];
  assign q_level   = (quo_level > LEVEL_MAX) ? LEVEL_MAX : quo_level;

  // signed average for the new zero
  assign cal_q    = div_quo[RAW_W-1:0];
  assign new_zero = quo_neg ? $signed(-cal_q) : $signed(cal_q);

  // operand selection for the shared units
  assign mlo_a   = (state == S_SNAP) ? abs_d : abs_r;
  assign mlo_b   = (state == S_SNAP) ? FRAC_W'(OUT_MAX) : lower_dead_fraction;
  assign div_rem = (state == S_CHECK) ? n_hi : '0;
  assign div_dvd = (state == S_CHECK) ?
                   {mlo_prod[FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}} : abs_sum;
  assign div_dvs = (state == S_CHECK) ? abs_r : RAW_W'(CAL_SAMPLES);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (opcode == OP_CAL) begin
            state_next = cal_fire ? S_CALDIV : S_WRITE;
          end else begin
            state_next = range_zero ? S_WRITE : S_THRESH;
          end
        end
      end
      S_THRESH: begin
        if (!mlo_busy && !mup_busy) state_next = S_SNAP;
      end
      S_SNAP: begin
        state_next = S_SCALE;
      end
      S_SCALE: begin
        if (!mlo_busy) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = (quo_neg || n_sat) ? S_WRITE : S_DIVIDE;
      end
      S_DIVIDE: begin
        if (!div_busy) state_next = S_WRITE;
      end
      S_CALDIV: begin
        if (!div_busy) state_next = S_WRITE;
      end
      S_WRITE: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    mlo_start     = 1'b0;
    mup_start     = 1'b0;
    div_req.start = 1'b0;
    div_req.steps = CAL_DIV_STEPS;
    unique case (state)
      S_IDLE: begin
        mlo_start     = accept && (opcode == OP_MAP) && !range_zero;
        mup_start     = accept && (opcode == OP_MAP) && !range_zero;
        div_req.start = accept && (opcode == OP_CAL) && cal_fire;
      end
      S_SNAP: begin
        mlo_start = 1'b1;
      end
      S_CHECK: begin
        div_req.start = !quo_neg && !n_sat;
        div_req.steps = MAP_DIV_STEPS;
      end
      S_THRESH, S_SCALE, S_DIVIDE, S_CALDIV, S_WRITE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale_raw      <= FULL_SCALE_RESET;
      lower_dead_fraction <= '0;
      upper_dead_fraction <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FULL_SCALE: full_scale_raw      <= cfg_data;
        CFG_LOWER_DEAD: lower_dead_fraction <= cfg_data[FRAC_W-1:0];
        CFG_UPPER_DEAD: upper_dead_fraction <= cfg_data[FRAC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // held sample, zero and calibration accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      held_sample  <= '0;
      zero_reading <= '0;
      cal_sum      <= '0;
      cal_count    <= '0;
    end else begin
      if (accept) begin
        if (sample_ready) begin
          held_sample <= raw_sample;
        end
        if (opcode == OP_CAL) begin
          if (cal_fire) begin
            cal_sum   <= '0;
            cal_count <= '0;
          end else begin
            cal_sum   <= sum_next;
            cal_count <= cnt_inc;
          end
        end
      end
      if ((state == S_CALDIV) && !div_busy) begin
        zero_reading <= new_zero;
      end
    end
  end

  // per-beat result staging
  always_ff @(posedge clk) begin
    if (accept) begin
      quo_neg   <= sum_neg;
      res_level <= '0;
      res_done  <= 1'b0;
    end
    if (state == S_SNAP) begin
      quo_neg <= d_neg ^ r_neg;
    end
    if ((state == S_CHECK) && !quo_neg && n_sat) begin
      res_level <= LEVEL_MAX;
    end
    if ((state == S_DIVIDE) && !div_busy) begin
      res_level <= q_level;
    end
    if ((state == S_CALDIV) && !div_busy) begin
      res_done <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == S_WRITE) && slot_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_WRITE) && slot_free) begin
      mapped_level     <= res_level;
      calibration_done <= res_done;
      zero_value       <= zero_reading;
    end
  end

  // lower threshold and numerator multiplier
  ldm_mul_serial #(
    .AW (RAW_W),
    .BW (FRAC_W)
  ) u_mul_lo (
    .clk   (clk),
    .rst   (rst),
    .start (mlo_start),
    .a     (mlo_a),
    .b     (mlo_b),
    .busy  (mlo_busy),
    .prod  (mlo_prod)
  );

  // upper threshold multiplier
  ldm_mul_serial #(
    .AW (RAW_W),
    .BW (FRAC_W)
  ) u_mul_up (
    .clk   (clk),
    .rst   (rst),
    .start (mup_start),
    .a     (abs_r),
    .b     (upper_dead_fraction),
    .busy  (mup_busy),
    .prod  (mup_prod)
  );

  // shared divider for the map quotient and the calibration average
  ldm_div_serial #(
    .DVD_W (QUO_W),
    .DVS_W (RAW_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .rem_init (div_rem),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_quo)
  );

endmodule

`default_nettype wire

@@ sv/ldm_checker.sv @@
// ldm_checker: port-level checks for load_cell_deadzone_mapper, bound to it
// depends on ldm_pkg and the top level's port list
`default_nettype none

module ldm_checker import ldm_pkg::*; #(
  parameter int OUT_MAX = OUT_MAX_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    sample_valid,
  input logic                    sample_stall,
  input logic                    result_valid,
  input logic                    result_stall,
  input logic [LEVEL_W-1:0]      mapped_level,
  input logic                    calibration_done,
  input logic signed [RAW_W-1:0] zero_value
);

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(mapped_level) && $stable(calibration_done) &&
      $stable(zero_value))
    else $error("stalled result beat changed");

  // an accepted sample beat keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample taken while previous beat still in work");

  // mapped level never exceeds the output maximum
  a_level_clamped: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> mapped_level <= LEVEL_W'(OUT_MAX))
    else $error("mapped level above output maximum");

  // a calibration result carries no level
  a_cal_level_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && calibration_done |-> mapped_level == '0)
    else $error("calibration beat with nonzero level");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind load_cell_deadzone_mapper ldm_checker #(
  .OUT_MAX (OUT_MAX)
) u_ldm_checker (
  .clk              (clk),
  .rst              (rst),
  .sample_valid     (sample_valid),
  .sample_stall     (sample_stall),
  .result_valid     (result_valid),
  .result_stall     (result_stall),
  .mapped_level     (mapped_level),
  .calibration_done (calibration_done),
  .zero_value       (zero_value)
);

`default_nettype wire

@@ bench/load_cell_deadzone_mapper_tb.sv @@
// load_cell_deadzone_mapper_tb: self-checking bench for the load cell deadzone mapper;
// a directed table of sample beats, then random phases under new register settings,
// checked beat by beat against a level predictor; depends on ldm_pkg and the mapper rtl
module load_cell_deadzone_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ldm_pkg::*;

  localparam int LEVEL_MAX = OUT_MAX_DEF;
  localparam int CAL_SET = CAL_SAMPLES_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // no register here, write is dropped
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 63;
  localparam longint RAW_MIN = -(longint'(1) << (RAW_W - 1));
  localparam longint RAW_MAX = (longint'(1) << (RAW_W - 1)) - 1;

  typedef struct {
    logic [LEVEL_W-1:0]     level;
    logic                   done;
    logic signed [RAW_W-1:0] zero;
  } level_beat_t;

  typedef struct {
    logic                    is_cfg;
    logic [CFG_IDX_W-1:0]    idx;
    logic [RAW_W-1:0]        data;
    logic                    op;
    logic                    rdy;
    logic signed [RAW_W-1:0] raw;
    logic                    known;
    level_beat_t             want;
  } row_t;

  // dut ports
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [RAW_W-1:0]        cfg_data = '0;
  logic                    sample_valid = 1'b0;
  logic                    sample_stall;
  logic                    opcode = OP_MAP;
  logic                    sample_ready = 1'b0;
  logic signed [RAW_W-1:0] raw_sample = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic [LEVEL_W-1:0]      mapped_level;
  logic                    calibration_done;
  logic signed [RAW_W-1:0] zero_value;

  // typed-in result travelling with the current sample beat
  logic        row_known = 1'b0;
  level_beat_t row_want;
  level_beat_t no_want;

  // predictor copy of the registers and state
  logic signed [RAW_W-1:0] cfg_full = FULL_SCALE_RESET;
  logic [FRAC_W-1:0]       cfg_lower = '0;
  logic [FRAC_W-1:0]       cfg_upper = '0;
  logic signed [RAW_W-1:0] held_raw = '0;
  logic signed [RAW_W-1:0] zero_ref = '0;
  logic signed [SUM_W-1:0] cal_acc = '0;
  logic [CNT_W-1:0]        cal_seen = '0;

  level_beat_t expected_levels[$];
  row_t        dir_rows[$];
  int          mismatches = 0;
  logic        idling_on = 1'b1;
  logic        hold_req = 1'b0;

  load_cell_deadzone_mapper dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .sample_valid     (sample_valid),
    .sample_stall     (sample_stall),
    .opcode           (opcode),
    .sample_ready     (sample_ready),
    .raw_sample       (raw_sample),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .mapped_level     (mapped_level),
    .calibration_done (calibration_done),
    .zero_value       (zero_value)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic signed [RAW_W-1:0] sat_raw(longint v);
    if (v < RAW_MIN) return RAW_W'(RAW_MIN);
    if (v > RAW_MAX) return RAW_W'(RAW_MAX);
    return RAW_W'(v);
  endfunction

  // level predictor: advances held sample, calibration and zero for one beat
  function automatic level_beat_t next_level(logic op, logic rdy, logic signed [RAW_W-1:0] raw);
    longint x, zr, fs, span, lo_th, hi_th, m;
    level_beat_t r;
    r.level = '0;
    r.done = 1'b0;
    if (rdy) held_raw = raw;
    x = held_raw;
    if (op == OP_MAP) begin
      zr = zero_ref;
      fs = cfg_full;
      span = fs - zr;
      lo_th = zr + (span * longint'(cfg_lower)) / 65536;
      hi_th = fs - (span * longint'(cfg_upper)) / 65536;
      // deadzone snap, lower side wins
      if (x < lo_th) x = zr;
      else if (x > hi_th) x = fs;
      if (span == 0) m = 0;
      else m = ((x - zr) * LEVEL_MAX) / span;
      if (m < 0) m = 0;
      if (m > LEVEL_MAX) m = LEVEL_MAX;
      r.level = LEVEL_W'(m);
    end else begin
      cal_acc = cal_acc + SUM_W'(x);
      cal_seen = cal_seen + 1'b1;
      if (cal_seen >= CAL_SET) begin
        zero_ref = RAW_W'(longint'(cal_acc) / CAL_SET);
        cal_acc = '0;
        cal_seen = '0;
        r.done = 1'b1;
      end
    end
    r.zero = zero_ref;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t ns: %s got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // random sample value: extremes, anywhere, between zero and full scale, or near either
  function automatic logic signed [RAW_W-1:0] pick_raw();
    longint lo, hi;
    lo = (zero_ref < cfg_full) ? longint'(zero_ref) : longint'(cfg_full);
    hi = (zero_ref < cfg_full) ? longint'(cfg_full) : longint'(zero_ref);
    case ($urandom_range(0, 9))
      0: return RAW_W'(RAW_MIN);
      1: return RAW_W'(RAW_MAX);
      2, 3: return RAW_W'($urandom);
      8: return sat_raw(longint'(cfg_full) + longint'($urandom_range(0, 64)) - 32);
      9: return sat_raw(longint'(zero_ref) + longint'($urandom_range(0, 64)) - 32);
      default: return RAW_W'(lo + longint'($urandom) % (hi - lo + 1));
    endcase
  endfunction

  function automatic void add_row(logic is_cfg, logic [CFG_IDX_W-1:0] idx,
                                  logic [RAW_W-1:0] data, logic op, logic rdy,
                                  logic signed [RAW_W-1:0] raw, logic known,
                                  logic [LEVEL_W-1:0] lvl, logic done,
                                  logic signed [RAW_W-1:0] zero);
    row_t r;
    r.is_cfg = is_cfg;
    r.idx = idx;
    r.data = data;
    r.op = op;
    r.rdy = rdy;
    r.raw = raw;
    r.known = known;
    r.want.level = lvl;
    r.want.done = done;
    r.want.zero = zero;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [RAW_W-1:0] data);
    add_row(1'b1, idx, data, OP_MAP, 1'b0, '0, 1'b0, '0, 1'b0, '0);
  endfunction

  function automatic void add_beat(logic op, logic rdy, logic signed [RAW_W-1:0] raw);
    add_row(1'b0, '0, '0, op, rdy, raw, 1'b0, '0, 1'b0, '0);
  endfunction

  function automatic void add_known(logic op, logic rdy, logic signed [RAW_W-1:0] raw,
                                    logic [LEVEL_W-1:0] lvl, logic done,
                                    logic signed [RAW_W-1:0] zero);
    add_row(1'b0, '0, '0, op, rdy, raw, 1'b1, lvl, done, zero);
  endfunction

  // offer one sample beat, hold it until taken, then maybe leave a gap
  task automatic send_beat(logic op, logic rdy, logic signed [RAW_W-1:0] raw,
                           logic known, level_beat_t want);
    sample_valid <= 1'b1;
    opcode <= op;
    sample_ready <= rdy;
    raw_sample <= raw;
    row_known <= known;
    row_want <= want;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // stop offering and wait for every pending result beat
  task automatic wait_drained();
    sample_valid <= 1'b0;
    do @(negedge clk); while (expected_levels.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RAW_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // result side stall: random bursts, one long hold on request, none when idling is off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // track register writes, predict on each sample beat, check each result beat
  always @(posedge clk) begin
    level_beat_t want;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FULL_SCALE: cfg_full = cfg_data;
          CFG_LOWER_DEAD: cfg_lower = cfg_data[FRAC_W-1:0];
          CFG_UPPER_DEAD: cfg_upper = cfg_data[FRAC_W-1:0];
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall) begin
        want = next_level(opcode, sample_ready, raw_sample);
        if (row_known) want = row_want;
        expected_levels.push_back(want);
      end
      if (result_valid && !result_stall) begin
        if (expected_levels.size() == 0) begin
          report_mismatch("result beat with nothing pending, level", mapped_level, 0);
        end else begin
          want = expected_levels.pop_front();
          if (mapped_level !== want.level)
            report_mismatch("mapped_level", mapped_level, want.level);
          if (calibration_done !== want.done)
            report_mismatch("calibration_done", calibration_done, want.done);
          if (zero_value !== want.zero)
            report_mismatch("zero_value", zero_value, want.zero);
        end
      end
    end
  end

  // stimulus
  initial begin
    int phase, sent, k, runlen;
    logic signed [RAW_W-1:0] centre, full_pick;
    logic [FRAC_W-1:0] low_pick, up_pick;
    longint off;

    no_want.level = '0;
    no_want.done = 1'b0;
    no_want.zero = '0;

    // reset settings: full scale at max, no deadzones, zero at 0
    add_known(OP_MAP, 1'b1, 0, 0, 1'b0, 0);
    add_known(OP_MAP, 1'b1, 8388607, LEVEL_MAX, 1'b0, 0);
    add_known(OP_MAP, 1'b1, -8388608, 0, 1'b0, 0);
    add_known(OP_MAP, 1'b0, 123, 0, 1'b0, 0);             // stale flag repeats held value
    add_beat(OP_MAP, 1'b1, 4194304);
    // calibration with a map beat and a stale sample in the middle
    add_known(OP_CAL, 1'b1, 100, 0, 1'b0, 0);
    add_known(OP_CAL, 1'b1, 200, 0, 1'b0, 0);
    add_beat(OP_MAP, 1'b1, 1000);
    add_known(OP_CAL, 1'b0, 7, 0, 1'b0, 0);
    add_known(OP_CAL, 1'b1, 300, 0, 1'b0, 0);
    add_known(OP_CAL, 1'b1, 2000, 0, 1'b1, 720);
    // negative sum rounds toward zero
    add_known(OP_CAL, 1'b1, -3, 0, 1'b0, 720);
    add_known(OP_CAL, 1'b0, 55, 0, 1'b0, 720);
    add_known(OP_CAL, 1'b1, -1, 0, 1'b0, 720);
    add_known(OP_CAL, 1'b0, 66, 0, 1'b0, 720);
    add_known(OP_CAL, 1'b0, 77, 0, 1'b1, -1);
    // full scale below zero, widest deadzones
    add_cfg(CFG_FULL_SCALE, 24'h800000);
    add_cfg(CFG_LOWER_DEAD, 24'h00FFFF);
    add_cfg(CFG_UPPER_DEAD, 24'hA5FFFF);
    add_beat(OP_MAP, 1'b1, -8388608);
    add_beat(OP_MAP, 1'b1, 8388607);
    add_beat(OP_MAP, 1'b1, -4000000);
    // full scale equal to zero, plus a write to the unused index
    add_cfg(CFG_FULL_SCALE, 24'hFFFFFF);
    add_cfg(CFG_SPARE, 24'h123456);
    add_known(OP_MAP, 1'b1, 5, 0, 1'b0, -1);
    // quarter and half deadzones
    add_cfg(CFG_FULL_SCALE, 24'h7FFFFF);
    add_cfg(CFG_LOWER_DEAD, 24'h004000);
    add_cfg(CFG_UPPER_DEAD, 24'h008000);
    add_beat(OP_MAP, 1'b1, 2000000);
    add_beat(OP_MAP, 1'b1, 5000000);
    add_beat(OP_MAP, 1'b1, 3000000);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_drained();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_beat(dir_rows[i].op, dir_rows[i].rdy, dir_rows[i].raw,
                  dir_rows[i].known, dir_rows[i].want);
      end
    end

    // random phases, each under fresh register settings
    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      idling_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
      case (phase)
        1: begin
          full_pick = RAW_W'(RAW_MIN);
          low_pick = '1;
          up_pick = '1;
        end
        2: begin
          full_pick = RAW_W'(RAW_MAX);
          low_pick = '0;
          up_pick = '0;
        end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            full_pick = RAW_W'($urandom);
          end else begin
            off = longint'($urandom) % (longint'(1) << $urandom_range(4, 23));
            if ($urandom_range(0, 4) == 0) off = -off;
            full_pick = sat_raw(longint'(zero_ref) + off);
          end
          low_pick = ($urandom_range(0, 3) == 0) ? FRAC_W'($urandom) :
                     FRAC_W'($urandom_range(0, 20000));
          up_pick = ($urandom_range(0, 3) == 0) ? FRAC_W'($urandom) :
                    FRAC_W'($urandom_range(0, 20000));
        end
      endcase
      write_reg(CFG_FULL_SCALE, full_pick);
      write_reg(CFG_LOWER_DEAD, {8'($urandom), low_pick});
      write_reg(CFG_UPPER_DEAD, {8'($urandom), up_pick});
      if (phase == 3 || $urandom_range(0, 2) == 0) write_reg(CFG_SPARE, RAW_W'($urandom));

      // long result hold while samples keep coming
      if (phase == 0) hold_req = 1'b1;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          // calibration run around one value, sometimes cut short, map beats mixed in
          0, 1, 2: begin
            centre = pick_raw();
            runlen = ($urandom_range(0, 4) == 0) ? $urandom_range(1, CAL_SET - 1) : CAL_SET;
            for (k = 0; k < runlen; k++) begin
              if ($urandom_range(0, 4) == 0) begin
                send_beat(OP_MAP, 1'b1, pick_raw(), 1'b0, no_want);
                sent++;
              end
              send_beat(OP_CAL, $urandom_range(0, 5) != 0,
                        sat_raw(longint'(centre) + longint'($urandom_range(0, 4000)) - 2000),
                        1'b0, no_want);
              sent++;
            end
          end
          // noise
          9: begin
            send_beat(($urandom_range(0, 1) != 0) ? OP_CAL : OP_MAP, $urandom_range(0, 1) != 0,
                      RAW_W'($urandom), 1'b0, no_want);
            sent++;
          end
          default: begin
            send_beat(OP_MAP, $urandom_range(0, 7) != 0, pick_raw(), 1'b0, no_want);
            sent++;
          end
        endcase
      end
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
